@@ rtl/core/hsa_pkg.sv @@
package hsa_pkg;

  localparam int unsigned HUE_FULL  = 23040;
  localparam int unsigned HUE_THIRD = 7680;
  localparam int unsigned HUE_SIXTH = 3840;

  localparam int unsigned QUEUE_DEPTH_DEFAULT = 4;

  localparam logic [0:0] CFG_MODE   = 1'b0;
  localparam logic [0:0] CFG_AMOUNT = 1'b1;

  localparam logic MODE_SAT = 1'b0;
  localparam logic MODE_HUE = 1'b1;

  // Classified pixel handed from the front to the back through the queue.
  typedef struct packed {
    logic [7:0]  mx;
    logic [7:0]  delta;
    logic [19:0] hnum;
    logic        hneg;
    logic [14:0] hbase;
    logic        fe;
  } front_t;

  localparam int unsigned FRONT_W = $bits(front_t);

  // Adjustment settings seen by the back.
  typedef struct packed {
    logic              mode;
    logic signed [10:0] amount;
  } cfg_t;

endpackage

@@ rtl/core/hsv_hue_saturation_adjust.sv @@
// Hue/saturation adjuster in the HSV domain. Each pixel pushed is converted to
// HSV, has its saturation scaled by (100+amount)/100 or its hue turned by amount
// degrees, and comes back as RGB with its frame-end flag. The block takes one
// pixel per clock and keeps that rate for as long as results are popped. Most of
// the pipeline is the pair of pipelined long dividers for hue and saturation,
// 16 stages with one quotient bit each; the fixed divisions by one hundred and
// by 3840 take one stage each through reciprocal multiplication, the division
// by 65535 an add and shift in front of the output register, and the other
// stages hold the hue wrap with the adjustment, the chroma products and the
// sector placement. While results are not popped the pipeline holds and the
// input queue fills; full rises once it holds QUEUE_DEPTH pixels. Write mode
// and amount only while no pixel is in flight.
module hsv_hue_saturation_adjust #(
  parameter int unsigned QUEUE_DEPTH = hsa_pkg::QUEUE_DEPTH_DEFAULT
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        push,
  output logic        full,
  input  logic [7:0]  in_red_in,
  input  logic [7:0]  in_green_in,
  input  logic [7:0]  in_blue_in,
  input  logic        in_frame_end_in,
  output logic        empty,
  input  logic        pop,
  output logic [7:0]  out_red_out,
  output logic [7:0]  out_green_out,
  output logic [7:0]  out_blue_out,
  output logic        out_frame_end_out,
  input  logic        cfg_we,
  input  logic [0:0]  cfg_index,
  input  logic [10:0] cfg_data
);
  import hsa_pkg::*;

  logic         mode_r;
  logic [10:0]  amount_r;
  cfg_t         cfg;
  front_t       front_item;
  front_t       q_item;
  logic         q_empty;
  logic         q_pop;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= MODE_SAT;
      amount_r <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_MODE:   mode_r   <= cfg_data[0];
        CFG_AMOUNT: amount_r <= cfg_data;
        default:    ;
      endcase
    end
  end

  assign cfg = '{mode: mode_r, amount: signed'(amount_r)};

  hsa_front u_front (
    .red(in_red_in), .green(in_green_in), .blue(in_blue_in),
    .frame_end(in_frame_end_in), .item(front_item)
  );

  hsa_queue #(.DEPTH(QUEUE_DEPTH), .WIDTH(FRONT_W)) u_queue (
    .clk(clk), .rst_n(rst_n),
    .push(push), .wdata(front_item), .full(full),
    .pop(q_pop), .empty(q_empty), .rdata(q_item)
  );

  hsa_back u_back (
    .clk(clk), .rst_n(rst_n), .cfg(cfg),
    .q_empty(q_empty), .q_item(q_item), .q_pop(q_pop),
    .out_empty(empty), .out_pop(pop),
    .red(out_red_out), .green(out_green_out), .blue(out_blue_out),
    .frame_end(out_frame_end_out)
  );

endmodule

@@ rtl/core/hsa_div.sv @@
module hsa_div #(
  parameter int unsigned DW = 8,
  parameter int unsigned QW = 16,
  parameter int unsigned SW = 1
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               en,
  input  logic               valid_i,
  input  logic [DW+QW-1:0]   num_i,
  input  logic [DW-1:0]      den_i,
  input  logic [SW-1:0]      side_i,
  output logic               valid_o,
  output logic [QW-1:0]      quo_o,
  output logic [SW-1:0]      side_o
);

  // One quotient bit per stage. The upper DW bits of num_i must be below den_i.
  logic [DW+QW-1:0] w_r    [QW];
  logic [DW-1:0]    den_r  [QW];
  logic [SW-1:0]    side_r [QW];
  logic             vld_r  [QW];

  logic [DW+QW-1:0] w_in    [QW];
  logic [DW-1:0]    den_in  [QW];
  logic [SW-1:0]    side_in [QW];
  logic             vld_in  [QW];

  for (genvar k = 0; k < QW; k++) begin : g_stage
    logic [DW:0]      trial;
    logic             ge;
    logic [DW:0]      diff;
    logic [DW+QW-1:0] w_nxt;

    if (k == 0) begin : g_first
      assign w_in[k]    = num_i;
      assign den_in[k]  = den_i;
      assign side_in[k] = side_i;
      assign vld_in[k]  = valid_i;
    end else begin : g_next
      assign w_in[k]    = w_r[k-1];
      assign den_in[k]  = den_r[k-1];
      assign side_in[k] = side_r[k-1];
      assign vld_in[k]  = vld_r[k-1];
    end

    always_comb begin
      trial = w_in[k][DW+QW-1:QW-1];
      ge    = trial >= {1'b0, den_in[k]};
      diff  = ge ? (trial - {1'b0, den_in[k]}) : trial;
      w_nxt = {diff[DW-1:0], w_in[k][QW-2:0], ge};
    end

    always_ff @(posedge clk) begin
      if (!rst_n) begin
        vld_r[k] <= 1'b0;
      end else if (en) begin
        vld_r[k] <= vld_in[k];
      end
    end

    always_ff @(posedge clk) begin
      if (en) begin
        w_r[k]    <= w_nxt;
        den_r[k]  <= den_in[k];
        side_r[k] <= side_in[k];
      end
    end
  end

  assign valid_o = vld_r[QW-1];
  assign quo_o   = w_r[QW-1][QW-1:0];
  assign side_o  = side_r[QW-1];

endmodule

@@ rtl/core/hsa_front.sv @@
module hsa_front (
  input  logic             [7:0] red,
  input  logic             [7:0] green,
  input  logic             [7:0] blue,
  input  logic                   frame_end,
  output hsa_pkg::front_t        item
);
  import hsa_pkg::*;

  logic [7:0] mx;
  logic [7:0] mn;
  logic [7:0] p;
  logic [7:0] q;
  logic [7:0] diff;

  always_comb begin
    mx = red;
    mn = red;
    if (green > mx) mx = green;
    if (blue > mx) mx = blue;
    if (green < mn) mn = green;
    if (blue < mn) mn = blue;

    // The sector follows the channel that holds the maximum, red first.
    if (mx == red) begin
      p = green;
      q = blue;
      item.hbase = 15'd0;
    end else if (mx == green) begin
      p = blue;
      q = red;
      item.hbase = 15'(HUE_THIRD);
    end else begin
      p = red;
      q = green;
      item.hbase = 15'(2 * HUE_THIRD);
    end

    item.hneg = p < q;
    diff      = item.hneg ? (q - p) : (p - q);
    item.hnum = 20'(diff) * 20'(HUE_SIXTH);
    item.mx    = mx;
    item.delta = mx - mn;
    item.fe    = frame_end;
  end

endmodule

@@ rtl/core/hsa_queue.sv @@
module hsa_queue #(
  parameter int unsigned DEPTH = 4,
  parameter int unsigned WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output logic [WIDTH-1:0] rdata
);

  localparam int unsigned AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [AW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [AW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [CW-1:0]    count_r, count_nxt;
  logic             do_push;
  logic             do_pop;

  assign full    = count_r == CW'(DEPTH);
  assign empty   = count_r == '0;
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem_r[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == AW'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == AW'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem_r[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ rtl/core/hsa_back.sv @@
module hsa_back (
  input  logic                   clk,
  input  logic                   rst_n,
  input  hsa_pkg::cfg_t          cfg,
  input  logic                   q_empty,
  input  hsa_pkg::front_t        q_item,
  output logic                   q_pop,
  output logic                   out_empty,
  input  logic                   out_pop,
  output logic             [7:0] red,
  output logic             [7:0] green,
  output logic             [7:0] blue,
  output logic                   frame_end
);
  import hsa_pkg::*;

  typedef struct packed {
    logic [7:0]  mx;
    logic        dz;
    logic        hneg;
    logic [14:0] hbase;
    logic        fe;
  } side1_t;

  typedef struct packed {
    logic [14:0] h;
    logic [15:0] s0;
    logic        kpos;
    logic [7:0]  mx;
    logic        fe;
  } side2_t;

  typedef struct packed {
    logic [23:0] cn;
    logic [23:0] mnum;
    logic [2:0]  sector;
    logic        fe;
  } side3_t;

  logic en;
  logic out_valid;

  // The whole pipeline moves together; it halts only while a result waits.
  assign en    = !out_valid || out_pop;
  assign q_pop = en && !q_empty;

  // Stage 1: hue and saturation divisions side by side.
  logic [23:0] snum;
  side1_t      s1_in, s1_out;
  logic        d1_valid;
  logic [15:0] hq;
  logic [15:0] sq;

  assign snum  = {q_item.delta, 16'd0} - 24'(q_item.delta);
  assign s1_in = '{mx: q_item.mx, dz: (q_item.delta == 8'd0), hneg: q_item.hneg,
                   hbase: q_item.hbase, fe: q_item.fe};

  hsa_div #(.DW(8), .QW(16), .SW($bits(side1_t))) u_div_hue (
    .clk(clk), .rst_n(rst_n), .en(en), .valid_i(!q_empty),
    .num_i({4'd0, q_item.hnum}), .den_i(q_item.delta), .side_i(s1_in),
    .valid_o(d1_valid), .quo_o(hq), .side_o(s1_out)
  );

  hsa_div #(.DW(8), .QW(16), .SW(1)) u_div_sat (
    .clk(clk), .rst_n(rst_n), .en(en), .valid_i(!q_empty),
    .num_i(snum), .den_i(q_item.mx), .side_i(1'b0),
    .valid_o(), .quo_o(sq), .side_o()
  );

  // Stage 2: hue wrap, then the selected adjustment.
  logic [15:0]        h_tmp;
  logic [14:0]        h_raw;
  logic [15:0]        s0;
  logic signed [11:0] k;
  logic signed [10:0] a_cl;
  logic signed [17:0] tot;
  logic [14:0]        h_adj;

  logic               s2_v_r;
  logic [14:0]        s2_h_r, s2_h_nxt;
  logic [26:0]        s2_num_r, s2_num_nxt;
  logic [15:0]        s2_s0_r;
  logic               s2_kpos_r;
  logic [7:0]         s2_mx_r;
  logic               s2_fe_r;

  always_comb begin
    if (!s1_out.hneg) begin
      h_tmp = 16'(s1_out.hbase) + 16'(hq[11:0]);
    end else begin
      h_tmp = 16'(s1_out.hbase) + 16'(HUE_FULL) - 16'(hq[11:0]);
    end
    if (h_tmp >= 16'(HUE_FULL)) h_tmp = h_tmp - 16'(HUE_FULL);
    h_raw = s1_out.dz ? 15'd0 : h_tmp[14:0];
    s0    = (s1_out.mx == 8'd0) ? 16'd0 : sq;

    k          = 12'sd100 + 12'(cfg.amount);
    s2_num_nxt = 27'(s0) * 27'(k[10:0]);

    if (cfg.amount > 11'sd360) begin
      a_cl = 11'sd360;
    end else if (cfg.amount < -11'sd360) begin
      a_cl = -11'sd360;
    end else begin
      a_cl = cfg.amount;
    end
    tot = 18'(signed'({1'b0, h_raw})) + (18'(a_cl) <<< 6);
    if (tot < 18'sd0) begin
      tot = tot + 18'sd23040;
    end else if (tot >= 18'sd23040) begin
      tot = tot - 18'sd23040;
    end
    h_adj = tot[14:0];

    s2_h_nxt = (cfg.mode == MODE_HUE) ? h_adj : h_raw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s2_v_r <= 1'b0;
    end else if (en) begin
      s2_v_r <= d1_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s2_h_r    <= s2_h_nxt;
      s2_num_r  <= s2_num_nxt;
      s2_s0_r   <= s0;
      s2_kpos_r <= k > 12'sd0;
      s2_mx_r   <= s1_out.mx;
      s2_fe_r   <= s1_out.fe;
    end
  end

  // Division of the scaled saturation by one hundred: a multiplication by the
  // rounded-up reciprocal of 2^34/100, exact for any 27-bit product.
  localparam logic [27:0] RECIP_100 = 28'd171798692;

  logic [54:0] pct_prod;
  side2_t      s2_side, d2_side_r;
  logic        d2_v_r;
  logic [19:0] d2_q_r;

  assign s2_side  = '{h: s2_h_r, s0: s2_s0_r, kpos: s2_kpos_r, mx: s2_mx_r, fe: s2_fe_r};
  assign pct_prod = 55'(s2_num_r) * 55'(RECIP_100);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d2_v_r <= 1'b0;
    end else if (en) begin
      d2_v_r <= s2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d2_q_r    <= pct_prod[53:34];
      d2_side_r <= s2_side;
    end
  end

  // Stage 3: chroma, distance from the sector center, sector number.
  logic [15:0] s_f;
  logic [12:0] t;
  logic [11:0] d;
  logic [2:0]  sector;

  logic        s3_v_r;
  logic [23:0] s3_cn_r;
  logic [11:0] s3_w_r;
  logic [2:0]  s3_sector_r;
  logic [7:0]  s3_mx_r;
  logic        s3_fe_r;

  always_comb begin
    if (cfg.mode == MODE_HUE) begin
      s_f = d2_side_r.s0;
    end else if (!d2_side_r.kpos) begin
      s_f = 16'd0;
    end else if (d2_q_r > 20'd65535) begin
      s_f = 16'hFFFF;
    end else begin
      s_f = d2_q_r[15:0];
    end

    if (d2_side_r.h < 15'(HUE_THIRD)) begin
      t = d2_side_r.h[12:0];
    end else if (d2_side_r.h < 15'(2 * HUE_THIRD)) begin
      t = 13'(d2_side_r.h - 15'(HUE_THIRD));
    end else begin
      t = 13'(d2_side_r.h - 15'(2 * HUE_THIRD));
    end
    d = (t >= 13'(HUE_SIXTH)) ? 12'(t - 13'(HUE_SIXTH)) : 12'(13'(HUE_SIXTH) - t);

    if (d2_side_r.h >= 15'(5 * HUE_SIXTH)) begin
      sector = 3'd5;
    end else if (d2_side_r.h >= 15'(4 * HUE_SIXTH)) begin
      sector = 3'd4;
    end else if (d2_side_r.h >= 15'(3 * HUE_SIXTH)) begin
      sector = 3'd3;
    end else if (d2_side_r.h >= 15'(2 * HUE_SIXTH)) begin
      sector = 3'd2;
    end else if (d2_side_r.h >= 15'(HUE_SIXTH)) begin
      sector = 3'd1;
    end else begin
      sector = 3'd0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s3_v_r <= 1'b0;
    end else if (en) begin
      s3_v_r <= d2_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s3_cn_r     <= 24'(d2_side_r.mx) * 24'(s_f);
      s3_w_r      <= 12'(HUE_SIXTH) - d;
      s3_sector_r <= sector;
      s3_mx_r     <= d2_side_r.mx;
      s3_fe_r     <= d2_side_r.fe;
    end
  end

  // Stage 4: chroma times the tent weight, and the offset term.
  logic [35:0] prod;
  logic        s4_v_r;
  logic [27:0] s4_x8_r;
  logic [23:0] s4_cn_r;
  logic [23:0] s4_mnum_r;
  logic [2:0]  s4_sector_r;
  logic        s4_fe_r;

  assign prod = 36'(s3_cn_r) * 36'(s3_w_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s4_v_r <= 1'b0;
    end else if (en) begin
      s4_v_r <= s3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s4_x8_r     <= prod[35:8];
      s4_cn_r     <= s3_cn_r;
      s4_mnum_r   <= {s3_mx_r, 16'd0} - 24'(s3_mx_r) - s3_cn_r;
      s4_sector_r <= s3_sector_r;
      s4_fe_r     <= s3_fe_r;
    end
  end

  // Dividing by 3840 is a shift by eight, done above, then a division by 15
  // as a multiplication by the rounded-up reciprocal of 2^32/15, exact for
  // any 28-bit value.
  localparam logic [28:0] RECIP_15 = 29'd286331154;

  logic [56:0] x_prod;
  side3_t      s4_side, d3_side_r;
  logic        d3_v_r;
  logic [23:0] d3_xn_r;

  assign s4_side = '{cn: s4_cn_r, mnum: s4_mnum_r, sector: s4_sector_r, fe: s4_fe_r};
  assign x_prod  = 57'(s4_x8_r) * 57'(RECIP_15);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      d3_v_r <= 1'b0;
    end else if (en) begin
      d3_v_r <= s4_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      d3_xn_r   <= x_prod[55:32];
      d3_side_r <= s4_side;
    end
  end

  // Stage 5: place chroma and the second component by sector.
  logic [23:0] rc, gc, bc;
  logic        s5_v_r;
  logic [23:0] s5_r_r, s5_g_r, s5_b_r;
  logic        s5_fe_r;

  always_comb begin
    case (d3_side_r.sector)
      3'd0: begin rc = d3_side_r.cn; gc = d3_xn_r;      bc = '0;           end
      3'd1: begin rc = d3_xn_r;      gc = d3_side_r.cn; bc = '0;           end
      3'd2: begin rc = '0;           gc = d3_side_r.cn; bc = d3_xn_r;      end
      3'd3: begin rc = '0;           gc = d3_xn_r;      bc = d3_side_r.cn; end
      3'd4: begin rc = d3_xn_r;      gc = '0;           bc = d3_side_r.cn; end
      default: begin rc = d3_side_r.cn; gc = '0;        bc = d3_xn_r;      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s5_v_r <= 1'b0;
    end else if (en) begin
      s5_v_r <= d3_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      s5_r_r  <= rc + d3_side_r.mnum;
      s5_g_r  <= gc + d3_side_r.mnum;
      s5_b_r  <= bc + d3_side_r.mnum;
      s5_fe_r <= d3_side_r.fe;
    end
  end

  // Final scale back to 8 bits. Each sum stays below 256 * 65535, so adding
  // its upper byte and one before the shift by sixteen divides by 65535 exactly.
  logic [23:0] r_sum, g_sum, b_sum;
  logic        out_v_r;
  logic [7:0]  red_r, green_r, blue_r;
  logic        fe_r;

  assign r_sum = s5_r_r + 24'(s5_r_r[23:16]) + 24'd1;
  assign g_sum = s5_g_r + 24'(s5_g_r[23:16]) + 24'd1;
  assign b_sum = s5_b_r + 24'(s5_b_r[23:16]) + 24'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (en) begin
      out_v_r <= s5_v_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      red_r   <= r_sum[23:16];
      green_r <= g_sum[23:16];
      blue_r  <= b_sum[23:16];
      fe_r    <= s5_fe_r;
    end
  end

  assign out_valid = out_v_r;
  assign red       = red_r;
  assign green     = green_r;
  assign blue      = blue_r;
  assign frame_end = fe_r;
  assign out_empty = !out_valid;

endmodule

@@ rtl/core/hsa_checker.sv @@
module hsa_checker (
  input logic       clk,
  input logic       rst_n,
  input logic       full,
  input logic       empty,
  input logic       pop,
  input logic [7:0] out_red_out,
  input logic [7:0] out_green_out,
  input logic [7:0] out_blue_out,
  input logic       out_frame_end_out
);

  // Reset flushes the pipeline, so no result is shown right after it.
  a_reset_empty: assert property (@(posedge clk) !rst_n |=> empty)
    else $error("result shown right after reset");

  // Reset also clears the input queue.
  a_reset_not_full: assert property (@(posedge clk) !rst_n |=> !full)
    else $error("queue full right after reset");

  // The pipeline is far deeper than two stages, so nothing can surface that soon.
  a_min_latency: assert property (@(posedge clk) !rst_n |=> ##1 empty)
    else $error("result appeared faster than the pipeline allows");

  // A result that is not popped stays put.
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (!empty && !pop) |=> (!empty && $stable(out_red_out) && $stable(out_green_out)
      && $stable(out_blue_out) && $stable(out_frame_end_out)))
    else $error("waiting result changed or vanished");

endmodule

bind hsv_hue_saturation_adjust hsa_checker u_hsa_checker (
  .clk(clk), .rst_n(rst_n), .full(full), .empty(empty), .pop(pop),
  .out_red_out(out_red_out), .out_green_out(out_green_out),
  .out_blue_out(out_blue_out), .out_frame_end_out(out_frame_end_out)
);
